[rtl/core/nrfp_pkg.sv]
// Shared types, constants and codes for the no-repeat random file picker.
// Used by every module under rtl/core; depends on nothing.
package nrfp_pkg;

	// Default sizes handed to the top level.
	localparam int POOLS_DEF     = 8;
	localparam int MAX_FILES_DEF = 256;

	// Marks are stored as rows of ROW_W bits, one bit per file.
	localparam int ROW_W  = 8;
	localparam int ROW_SH = 3;

	// Opcodes of an input word.
	localparam logic OP_PICK  = 1'b0;
	localparam logic OP_RESET = 1'b1;

	// Saturation point of the mark tally.
	localparam logic [7:0] TALLY_MAX = 8'd255;

	// Width of the roll and its bit count for the remainder unit.
	localparam int ROLL_W = 32;

	// Controller states.
	typedef enum logic [3:0] {
		S_CLR_ALL,
		S_IDLE,
		S_CHECK,
		S_CLR_POOL,
		S_PREP,
		S_COUNT,
		S_DIV,
		S_SEARCH,
		S_COMMIT,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clr_all;
		logic clr_pool;
		logic prep;
		logic scan;
		logic srch;
		logic div_start;
		logic restart;
		logic commit;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       op_reset;
		logic       bad;
		logic       need_clear;
		logic       sweep_done;
		logic       pool_done;
		logic       scan_done;
		logic       found;
		logic       div_done;
		logic       elig_zero;
		logic [7:0] hit_f;
	} st_t;

endpackage

[rtl/core/no_repeat_random_file_picker_top.sv]
// No-repeat random file picker, one request at a time. The time from acceptance to a
// valid result is set by the row scans of the mark memory and the bit-serial remainder
// unit, plus a clearing sweep of the pool's ceil(MAX_FILES/8) rows when its bag is full.
// An empty pool skips the scans. After reset and after a reset request the mark
// memory is cleared one row a cycle, POOLS*ceil(MAX_FILES/8) rows, with in_ready low.
module no_repeat_random_file_picker_top #(
	parameter int POOLS     = nrfp_pkg::POOLS_DEF,
	parameter int MAX_FILES = nrfp_pkg::MAX_FILES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [2:0]                   pool_id,
	input  logic [7:0]                   pool_size,
	input  logic [nrfp_pkg::ROLL_W-1:0]  roll,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   chosen_file
);

	nrfp_pkg::cmd_t cmd;
	nrfp_pkg::st_t  st;

	// Sequencer.
	nrfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	// Marks, counters and arithmetic.
	nrfp_dp #(
		.POOLS     (POOLS),
		.MAX_FILES (MAX_FILES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.opcode      (opcode),
		.pool_id     (pool_id),
		.pool_size   (pool_size),
		.roll        (roll),
		.chosen_file (chosen_file)
	);

	// The mark memory port has one user at a time.
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_all, cmd.clr_pool, cmd.scan, cmd.srch, cmd.commit}))
		else $error("mark memory port used by two operations at once");

	// The remainder unit never starts on an empty eligible set.
	a_elig_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.elig_zero)
		else $error("eligible count is zero at the modulo step");

	// A committed pick is a real file.
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (st.hit_f != 8'd0))
		else $error("committed pick is file zero");

	// A new result is only loaded once the output slot is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result loaded over one not yet taken");

endmodule

[rtl/core/nrfp_mod.sv]
// Iterative remainder unit: 32-bit roll modulo an 8-bit count, one bit a cycle.
// Depends on nrfp_pkg.
module nrfp_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [nrfp_pkg::ROLL_W-1:0]  a,
	input  logic [7:0]                   d,
	output logic [7:0]                   rem,
	output logic                         done
);

	logic [nrfp_pkg::ROLL_W-1:0] a_q;
	logic [7:0]                  d_q;
	logic [7:0]                  rem_q;
	logic [5:0]                  cnt_q;
	logic                        done_q;
	logic [8:0]                  trial;

	// Shift the next dividend bit into the partial remainder.
	assign trial = {rem_q, a_q[nrfp_pkg::ROLL_W-1]};

	// Restoring step: subtract the divisor when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 6'(nrfp_pkg::ROLL_W);
			done_q <= 1'b0;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			d_q   <= d;
			rem_q <= '0;
		end else if (cnt_q != 6'd0) begin
			a_q <= a_q << 1;
			if (trial >= {1'b0, d_q}) begin
				rem_q <= 8'(trial - {1'b0, d_q});
			end else begin
				rem_q <= trial[7:0];
			end
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

[rtl/core/nrfp_dp.sv]
// Datapath of the file picker: mark memory, tallies, last picks, scan counters,
// the remainder unit and the output register. Depends on nrfp_pkg and nrfp_mod.
module nrfp_dp #(
	parameter int POOLS     = nrfp_pkg::POOLS_DEF,
	parameter int MAX_FILES = nrfp_pkg::MAX_FILES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nrfp_pkg::cmd_t               cmd,
	output nrfp_pkg::st_t                st,
	input  logic                         opcode,
	input  logic [2:0]                   pool_id,
	input  logic [7:0]                   pool_size,
	input  logic [nrfp_pkg::ROLL_W-1:0]  roll,
	output logic [7:0]                   chosen_file
);

	localparam int RPP   = (MAX_FILES + nrfp_pkg::ROW_W - 1) / nrfp_pkg::ROW_W;
	localparam int DEPTH = POOLS * RPP;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RIW   = (RPP > 1) ? $clog2(RPP) : 1;
	localparam int RCW   = $clog2(RPP + 1);
	localparam int PW    = (POOLS > 1) ? $clog2(POOLS) : 1;

	// Mark memory and per-pool state.
	logic [nrfp_pkg::ROW_W-1:0] mem [DEPTH];
	logic [7:0] tally_q [POOLS];
	logic [7:0] last_q  [POOLS];

	// Request fields.
	logic                        op_q;
	logic                        pool_bad_q;
	logic [PW-1:0]               pool_q;
	logic [7:0]                  n_q;
	logic [nrfp_pkg::ROLL_W-1:0] roll_q;

	// Sweep and scan counters.
	logic [AW-1:0]  ca_q;
	logic [RCW-1:0] r_q;
	logic           skip_q;
	logic [7:0]     elig_q;
	logic [7:0]     seen_q;
	logic           found_q;
	logic [RIW-1:0] hit_row_q;
	logic [nrfp_pkg::ROW_W-1:0] hit_data_q;
	logic [7:0]     hit_f_q;
	logic [7:0]     chosen_file_q;

	// Read pipeline.
	logic                       d_s1;
	logic [RIW-1:0]             rrow_s1;
	logic [nrfp_pkg::ROW_W-1:0] rdata_s1;

	logic [4:0]                 pool_ext;
	logic [7:0]                 n_sat;
	logic [8:0]                 nsum;
	logic [RCW-1:0]             nrows;
	logic [7:0]                 tally_cur;
	logic [7:0]                 last_cur;
	logic [AW-1:0]              base;
	logic [AW-1:0]              rd_addr;
	logic                       rd_en;
	logic [nrfp_pkg::ROW_W-1:0] row_mask;
	logic [3:0]                 row_cnt;
	logic [7:0]                 k;
	logic                       hit_now;
	logic [2:0]                 sel;
	logic [8:0]                 fb;
	logic [3:0]                 c;
	logic [7:0]                 target;
	logic                       div_done;

	// Field decode on the ports and saturation of the file count.
	assign pool_ext = {2'b00, pool_id};
	assign n_sat    = ({1'b0, pool_size} > 9'(MAX_FILES)) ? 8'(MAX_FILES) : pool_size;

	// Views of the current request.
	assign nsum      = {1'b0, n_q} + 9'd7;
	assign nrows     = RCW'(nsum >> nrfp_pkg::ROW_SH);
	assign tally_cur = tally_q[pool_q];
	assign last_cur  = last_q[pool_q];
	assign base      = AW'(pool_q) * AW'(RPP);
	assign rd_addr   = base + AW'(r_q[RIW-1:0]);
	assign rd_en     = (cmd.scan || cmd.srch) && (r_q < nrows) && !found_q;

	// Eligible files in the row that just came out of the memory.
	always_comb begin
		row_mask = '0;
		row_cnt  = '0;
		fb       = '0;
		for (int b = 0; b < nrfp_pkg::ROW_W; b++) begin
			fb = (9'(rrow_s1) << nrfp_pkg::ROW_SH) + 9'(b) + 9'd1;
			row_mask[b] = !rdata_s1[b] && (fb <= {1'b0, n_q}) &&
				!(skip_q && (fb == {1'b0, last_cur}));
			row_cnt = row_cnt + 4'(row_mask[b]);
		end
	end

	// The target lies in this row once the running count passes it.
	assign k       = target - seen_q;
	assign hit_now = cmd.srch && d_s1 && !found_q &&
		(({1'b0, seen_q} + 9'(row_cnt)) > {1'b0, target});

	// Pick the k-th eligible bit of the row.
	always_comb begin
		sel = '0;
		c   = '0;
		for (int b = 0; b < nrfp_pkg::ROW_W; b++) begin
			if (row_mask[b]) begin
				if (c == k[3:0]) begin
					sel = 3'(b);
				end
				c = c + 4'd1;
			end
		end
	end

	// Remainder of the roll by the eligible count.
	nrfp_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.a      (roll_q),
		.d      (elig_q),
		.rem    (target),
		.done   (div_done)
	);

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= opcode;
			pool_bad_q <= pool_ext >= 5'(POOLS);
			pool_q     <= pool_ext[PW-1:0];
			n_q        <= n_sat;
			roll_q     <= roll;
		end
	end

	// Counters of the sweeps and scans.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_q    <= '0;
			r_q     <= '0;
			d_s1    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			d_s1 <= rd_en;
			if (cmd.load) begin
				ca_q <= '0;
				r_q  <= '0;
			end else if (cmd.clr_all) begin
				ca_q <= ca_q + AW'(1);
			end
			if (cmd.clr_pool) begin
				r_q <= r_q + RCW'(1);
			end else if (cmd.prep || cmd.restart) begin
				r_q     <= '0;
				found_q <= 1'b0;
			end else if (rd_en) begin
				r_q <= r_q + RCW'(1);
			end
			if (hit_now) begin
				found_q <= 1'b1;
			end
		end
	end

	// Eligible count, running count and the hit.
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			skip_q <= (tally_cur == 8'd0) && (n_q > 8'd1) && (last_cur != 8'd0);
			elig_q <= '0;
		end else if (cmd.scan && d_s1) begin
			elig_q <= elig_q + 8'(row_cnt);
		end
		if (cmd.restart) begin
			seen_q <= '0;
		end else if (cmd.srch && d_s1 && !found_q) begin
			seen_q <= seen_q + 8'(row_cnt);
		end
		if (hit_now) begin
			hit_row_q  <= rrow_s1;
			hit_data_q <= rdata_s1 | (nrfp_pkg::ROW_W'(1) << sel);
			hit_f_q    <= 8'((9'(rrow_s1) << nrfp_pkg::ROW_SH) + 9'(sel) + 9'd1);
		end
		if (cmd.out_load) begin
			chosen_file_q <= pool_bad_q || (n_q == 8'd0) ? 8'd0 : hit_f_q;
		end
	end

	// Mark memory: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (cmd.clr_all) begin
			mem[ca_q] <= '0;
		end else if (cmd.clr_pool) begin
			mem[rd_addr] <= '0;
		end else if (cmd.commit) begin
			mem[base + AW'(hit_row_q)] <= hit_data_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			rrow_s1  <= r_q[RIW-1:0];
		end
	end

	// Tallies and last picks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < POOLS; p++) begin
				tally_q[p] <= '0;
				last_q[p]  <= '0;
			end
		end else if (cmd.clr_all) begin
			for (int p = 0; p < POOLS; p++) begin
				tally_q[p] <= '0;
				last_q[p]  <= '0;
			end
		end else if (cmd.clr_pool) begin
			tally_q[pool_q] <= '0;
		end else if (cmd.commit) begin
			if (tally_cur != nrfp_pkg::TALLY_MAX) begin
				tally_q[pool_q] <= tally_cur + 8'd1;
			end
			last_q[pool_q] <= hit_f_q;
		end
	end

	// Status back to the controller.
	assign st.op_reset   = op_q == nrfp_pkg::OP_RESET;
	assign st.bad        = pool_bad_q || (n_q == 8'd0);
	assign st.need_clear = tally_cur >= n_q;
	assign st.sweep_done = ca_q == AW'(DEPTH - 1);
	assign st.pool_done  = r_q == RCW'(RPP - 1);
	assign st.scan_done  = (r_q == nrows) && !d_s1;
	assign st.found      = found_q;
	assign st.div_done   = div_done;
	assign st.elig_zero  = elig_q == 8'd0;
	assign st.hit_f      = hit_f_q;

	assign chosen_file = chosen_file_q;

endmodule

[rtl/core/nrfp_ctrl.sv]
// Controller state machine of the file picker: sequences sweeps, scans and the
// remainder unit, and owns both handshakes. Depends on nrfp_pkg.
module nrfp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output nrfp_pkg::cmd_t cmd,
	input  nrfp_pkg::st_t  st
);

	nrfp_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	// State and output valid registers; reset starts with a clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nrfp_pkg::S_CLR_ALL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			nrfp_pkg::S_CLR_ALL: begin
				cmd.clr_all = 1'b1;
				if (st.sweep_done) begin
					state_d = nrfp_pkg::S_IDLE;
				end
			end
			nrfp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = nrfp_pkg::S_CHECK;
				end
			end
			nrfp_pkg::S_CHECK: begin
				priority if (st.op_reset) begin
					state_d = nrfp_pkg::S_CLR_ALL;
				end else if (st.bad) begin
					state_d = nrfp_pkg::S_RESULT;
				end else if (st.need_clear) begin
					state_d = nrfp_pkg::S_CLR_POOL;
				end else begin
					state_d = nrfp_pkg::S_PREP;
				end
			end
			nrfp_pkg::S_CLR_POOL: begin
				cmd.clr_pool = 1'b1;
				if (st.pool_done) begin
					state_d = nrfp_pkg::S_PREP;
				end
			end
			nrfp_pkg::S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = nrfp_pkg::S_COUNT;
			end
			nrfp_pkg::S_COUNT: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					cmd.div_start = 1'b1;
					state_d       = nrfp_pkg::S_DIV;
				end
			end
			nrfp_pkg::S_DIV: begin
				if (st.div_done) begin
					cmd.restart = 1'b1;
					state_d     = nrfp_pkg::S_SEARCH;
				end
			end
			nrfp_pkg::S_SEARCH: begin
				cmd.srch = 1'b1;
				if (st.found) begin
					state_d = nrfp_pkg::S_COMMIT;
				end
			end
			nrfp_pkg::S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = nrfp_pkg::S_RESULT;
			end
			nrfp_pkg::S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = nrfp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nrfp_pkg::S_CLR_ALL;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[test/nrfp_checker.sv]
// Checker for the no-repeat random file picker: watches both channels,
// predicts each chosen file from its own copy of the bags, and counts mismatches.
// Depends on nrfp_pkg for the opcode codes.
module nrfp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        opcode,
	input  logic [2:0]  pool_id,
	input  logic [7:0]  pool_size,
	input  logic [31:0] roll,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  chosen_file,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPOOL = 8;
	localparam int NFILE = 256;

	bit        played [NPOOL][NFILE];
	bit [7:0]  play_tally [NPOOL];
	bit [7:0]  prev_file [NPOOL];
	bit [7:0]  index_q [$];

	// Clear one pool's bag.
	function automatic void empty_bag(int p);
		for (int f = 0; f < NFILE; f++) played[p][f] = 1'b0;
		play_tally[p] = 8'd0;
	endfunction

	function automatic bit is_played(int p, int f, int n);
		if (f == 0 || f > n) return 1'b0;
		return played[p][f-1];
	endfunction

	function automatic void mark_played(int p, int f, int n);
		if (f == 0 || f > n) return;
		if (!played[p][f-1]) begin
			played[p][f-1] = 1'b1;
			if (play_tally[p] != 8'd255) play_tally[p]++;
		end
	endfunction

	// Draw one file from pool p without replacement.
	function automatic bit [7:0] draw_file(int p, int n, bit [31:0] r);
		int  elig;
		int  seen;
		int  goal;
		bit  skip;
		elig = 0;
		seen = 0;
		if (n == 0) return 8'd0;
		if (play_tally[p] >= n) empty_bag(p);
		skip = play_tally[p] == 0 && n > 1 && prev_file[p] > 0;
		for (int f = 1; f <= n; f++)
			if (!is_played(p, f, n) && !(skip && f == prev_file[p])) elig++;
		if (elig == 0) begin
			empty_bag(p);
			for (int f = 1; f <= n; f++)
				if (!(skip && f == prev_file[p])) elig++;
		end
		if (elig == 0) return 8'(r % n + 1);
		goal = int'(r % elig);
		for (int f = 1; f <= n; f++) begin
			if (is_played(p, f, n) || (skip && f == prev_file[p])) continue;
			if (seen == goal) begin
				mark_played(p, f, n);
				prev_file[p] = 8'(f);
				return 8'(f);
			end
			seen++;
		end
		for (int f = 1; f <= n; f++)
			if (!is_played(p, f, n)) begin
				mark_played(p, f, n);
				prev_file[p] = 8'(f);
				return 8'(f);
			end
		return 8'(r % n + 1);
	endfunction

	assign pending = index_q.size();

	// Predict on accepted input words, compare on accepted output words.
	always @(posedge clk or negedge arst_n) begin
		bit [7:0] want;
		if (!arst_n) begin
			for (int p = 0; p < NPOOL; p++) begin
				empty_bag(p);
				prev_file[p] = 8'd0;
			end
			index_q.delete();
			fail_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (index_q.size() == 0) begin
					$display("%0t: unexpected word chosen_file=%0d", $time, chosen_file);
					fail_count <= fail_count + 1;
				end else begin
					want = index_q.pop_front();
					if (chosen_file !== want) begin
						$display("%0t: chosen_file expected %0d actual %0d",
							$time, want, chosen_file);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (opcode == nrfp_pkg::OP_RESET) begin
					for (int p = 0; p < NPOOL; p++) begin
						empty_bag(p);
						prev_file[p] = 8'd0;
					end
				end else begin
					index_q.push_back(draw_file(pool_id, pool_size, roll));
				end
			end
		end
	end
endmodule

[test/tb_top.sv]
// Top of the file picker testbench: clock, reset, request stimulus with
// bursty sending and stalling receiver, and the verdict. Depends on nrfp_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [2:0]  pool_id;
	logic [7:0]  pool_size;
	logic [31:0] roll;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  chosen_file;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	bit          timed_out;

	no_repeat_random_file_picker_top uut (.*);

	nrfp_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver stalls on its own pattern: runs of ready and of stall.
	initial begin
		int run;
		out_ready = 1'b0;
		forever begin
			run = $urandom_range(1, 12);
			out_ready <= ($urandom_range(0, 2) != 0);
			repeat (run) @(negedge clk);
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000 && !timed_out) begin
			timed_out = 1'b1;
			$display("no_repeat_random_file_picker_top verification failed");
			$finish;
		end
	end

	// Present one word and hold it until accepted.
	task automatic send_word(logic op, logic [2:0] p, logic [7:0] n, logic [31:0] r);
		in_valid   <= 1'b1;
		opcode     <= op;
		pool_id    <= p;
		pool_size  <= n;
		roll       <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 30)) @(negedge clk);
	endtask

	initial begin
		int burst;
		int sent;
		logic [7:0] n;
		idle_cycles = 0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = nrfp_pkg::OP_PICK;
		pool_id = '0;
		pool_size = '0;
		roll = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pool, single file, skip of last pick, full bag, extremes.
		send_word(nrfp_pkg::OP_PICK, 3'd0, 8'd0, 32'hFFFF_FFFF);
		send_word(nrfp_pkg::OP_PICK, 3'd1, 8'd1, 32'd7);
		send_word(nrfp_pkg::OP_PICK, 3'd1, 8'd1, 32'd0);
		for (int i = 0; i < 4; i++) send_word(nrfp_pkg::OP_PICK, 3'd2, 8'd3, 32'(i));
		send_word(nrfp_pkg::OP_PICK, 3'd2, 8'd2, 32'hFFFF_FFFF);
		send_word(nrfp_pkg::OP_PICK, 3'd7, 8'd255, 32'hFFFF_FFFF);
		send_word(nrfp_pkg::OP_PICK, 3'd7, 8'd255, 32'd0);
		send_word(nrfp_pkg::OP_PICK, 3'd7, 8'd4, 32'h8000_0000);
		send_word(nrfp_pkg::OP_PICK, 3'd7, 8'd255, 32'h5555_5555);
		send_word(nrfp_pkg::OP_RESET, 3'd5, 8'hAA, 32'hAAAA_AAAA);
		send_word(nrfp_pkg::OP_PICK, 3'd2, 8'd3, 32'd1);
		send_word(nrfp_pkg::OP_PICK, 3'd6, 8'd128, 32'h1234_5678);
		drop_valid();

		// Random: mostly small pools so bags fill and clear often.
		sent = 0;
		while (sent < 1300) begin
			burst = $urandom_range(1, 20);
			repeat (burst) begin
				case ($urandom_range(0, 19))
					0:       n = 8'($urandom_range(0, 255));
					1:       n = 8'd255;
					2, 3:    n = 8'($urandom_range(0, 2));
					default: n = 8'($urandom_range(1, 12));
				endcase
				send_word(($urandom_range(0, 60) == 0) ? nrfp_pkg::OP_RESET
					: nrfp_pkg::OP_PICK, 3'($urandom), n, $urandom);
				sent++;
			end
			if ($urandom_range(0, 3) != 0) drop_valid();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && !timed_out)
			$display("no_repeat_random_file_picker_top verification clean");
		else
			$display("no_repeat_random_file_picker_top verification failed");
		$finish;
	end
endmodule

[filelist.f]
rtl/core/nrfp_pkg.sv
rtl/core/nrfp_mod.sv
rtl/core/nrfp_dp.sv
rtl/core/nrfp_ctrl.sv
rtl/core/no_repeat_random_file_picker_top.sv
test/nrfp_checker.sv
test/tb_top.sv
